/* hw/rtl/cbd_pkg.sv */
package cbd_pkg;

	// action codes of an input item
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// target codes of a result item
	localparam logic [2:0] TGT_NONE   = 3'd0;
	localparam logic [2:0] TGT_RAM    = 3'd1;
	localparam logic [2:0] TGT_VIDEO  = 3'd2;
	localparam logic [2:0] TGT_AUDIO  = 3'd3;
	localparam logic [2:0] TGT_DMA    = 3'd4;
	localparam logic [2:0] TGT_JOYPAD = 3'd5;

	// cpu bus map
	localparam logic [15:0] ADDR_RAM_END   = 16'h1FFF;
	localparam logic [15:0] ADDR_VIDEO_END = 16'h3FFF;
	localparam logic [15:0] ADDR_AUDIO_END = 16'h4013;
	localparam logic [15:0] ADDR_OAM_DMA   = 16'h4014;
	localparam logic [15:0] ADDR_APU_STAT  = 16'h4015;
	localparam logic [15:0] ADDR_JOY1      = 16'h4016;
	localparam logic [15:0] ADDR_JOY2      = 16'h4017;

	// ram mirror window is 13 address bits
	localparam int unsigned BUS_RAM_AW = 13;

	// master clock phase counter
	localparam logic [2:0] PHASE_CPU0 = 3'd0;
	localparam logic [2:0] PHASE_CPU1 = 3'd3;
	localparam logic [2:0] PHASE_LAST = 3'd5;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [7:0]  device_rdata;
	} cbd_req_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic [2:0] target;
		logic       cpu_clock_enable;
		logic       dma_busy;
		logic       dma_byte_valid;
		logic [7:0] dma_byte_index;
		logic [7:0] dma_byte;
	} cbd_rsp_t;

	// result of the decode stage, ram data still to be merged
	typedef struct packed {
		cbd_rsp_t rsp;
		logic     rd_from_ram;
		logic     dma_from_ram;
	} cbd_s1_t;

	// ram access requested by the decode stage
	typedef struct packed {
		logic                  we;
		logic [BUS_RAM_AW-1:0] waddr;
		logic [7:0]            wdata;
		logic                  re;
		logic [BUS_RAM_AW-1:0] raddr;
	} cbd_ram_acc_t;

	// target of a cpu read (also used for dma fetches)
	function automatic logic [2:0] read_target(input logic [15:0] a);
		logic [2:0] t;
		if (a <= ADDR_RAM_END) begin
			t = TGT_RAM;
		end else if (a <= ADDR_VIDEO_END) begin
			t = TGT_VIDEO;
		end else if (a == ADDR_APU_STAT) begin
			t = TGT_AUDIO;
		end else if (a == ADDR_JOY1 || a == ADDR_JOY2) begin
			t = TGT_JOYPAD;
		end else begin
			t = TGT_NONE;
		end
		return t;
	endfunction

endpackage

/* hw/rtl/cbd_ram.sv */
module cbd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/cbd_ctrl.sv */
module cbd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  cbd_pkg::cbd_req_t     req,
	output cbd_pkg::cbd_ram_acc_t ram_acc,
	output logic                  s1_valid,
	output cbd_pkg::cbd_s1_t      s1
);

	import cbd_pkg::*;

	logic [7:0] page_q, page_d;
	logic [7:0] offset_q, offset_d;
	logic       running_q, running_d;
	logic       waiting_q, waiting_d;
	logic [2:0] phase_q, phase_d;
	logic       s1_valid_q;
	cbd_s1_t    s1_d, s1_s1;
	cbd_ram_acc_t acc;

	logic [2:0]  ph;
	logic [2:0]  rt;
	logic [15:0] src;

	always_comb begin
		page_d    = page_q;
		offset_d  = offset_q;
		running_d = running_q;
		waiting_d = waiting_q;
		phase_d   = phase_q;
		s1_d      = '0;
		acc       = '0;
		ph        = (phase_q > PHASE_LAST) ? PHASE_CPU0 : phase_q;
		src       = {page_q, offset_q};
		rt        = TGT_NONE;

		case (req.action)
			ACT_WRITE: begin
				if (req.addr <= ADDR_RAM_END) begin
					acc.we          = 1'b1;
					acc.waddr       = req.addr[BUS_RAM_AW-1:0];
					acc.wdata       = req.wdata;
					s1_d.rsp.target = TGT_RAM;
				end else if (req.addr <= ADDR_VIDEO_END) begin
					s1_d.rsp.target = TGT_VIDEO;
				end else if (req.addr <= ADDR_AUDIO_END || req.addr == ADDR_APU_STAT
						|| req.addr == ADDR_JOY2) begin
					s1_d.rsp.target = TGT_AUDIO;
				end else if (req.addr == ADDR_OAM_DMA) begin
					page_d          = req.wdata;
					offset_d        = 8'd0;
					running_d       = 1'b1;
					s1_d.rsp.target = TGT_DMA;
				end else if (req.addr == ADDR_JOY1) begin
					s1_d.rsp.target = TGT_JOYPAD;
				end
			end
			ACT_READ: begin
				rt              = read_target(req.addr);
				s1_d.rsp.target = rt;
				if (rt == TGT_RAM) begin
					s1_d.rd_from_ram = 1'b1;
					acc.re           = 1'b1;
					acc.raddr        = req.addr[BUS_RAM_AW-1:0];
				end else if (rt != TGT_NONE) begin
					s1_d.rsp.rdata = req.device_rdata;
				end
			end
			ACT_TICK: begin
				if (ph == PHASE_CPU0 || ph == PHASE_CPU1) begin
					if (!running_q) begin
						s1_d.rsp.cpu_clock_enable = 1'b1;
					end else if (waiting_q) begin
						// dummy cycle, align to the odd slot
						if (ph == PHASE_CPU1) begin
							waiting_d = 1'b0;
						end
					end else if (ph == PHASE_CPU0) begin
						rt                      = read_target(src);
						s1_d.rsp.target         = rt;
						s1_d.rsp.dma_byte_valid = 1'b1;
						s1_d.rsp.dma_byte_index = offset_q;
						if (rt == TGT_RAM) begin
							s1_d.dma_from_ram = 1'b1;
							acc.re            = 1'b1;
							acc.raddr         = src[BUS_RAM_AW-1:0];
						end else if (rt != TGT_NONE) begin
							s1_d.rsp.dma_byte = req.device_rdata;
						end
					end else begin
						offset_d = offset_q + 8'd1;
						if (offset_q == 8'hFF) begin
							running_d = 1'b0;
							waiting_d = 1'b1;
						end
					end
				end
				phase_d = (phase_q >= PHASE_LAST) ? PHASE_CPU0 : phase_q + 3'd1;
			end
			default: begin
			end
		endcase

		s1_d.rsp.dma_busy = running_d;
		acc.we            = acc.we & fire;
		acc.re            = acc.re & fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q     <= '0;
			offset_q   <= '0;
			running_q  <= 1'b0;
			waiting_q  <= 1'b1;
			phase_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= fire;
			if (fire) begin
				page_q    <= page_d;
				offset_q  <= offset_d;
				running_q <= running_d;
				waiting_q <= waiting_d;
				phase_q   <= phase_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			s1_s1 <= s1_d;
		end
	end

	assign ram_acc  = acc;
	assign s1_valid = s1_valid_q;
	assign s1       = s1_s1;

endmodule

/* hw/rtl/cbd_outbuf.sv */
module cbd_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cbd_pkg::cbd_rsp_t  push_data,
	input  logic               pop,
	output logic [1:0]         count,
	output cbd_pkg::cbd_rsp_t  head
);

	import cbd_pkg::*;

	cbd_rsp_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign count = cnt_q;
	assign head  = entry_q[rd_ptr_q];

endmodule

/* hw/rtl/console_bus_decode_with_sprite_dma.sv */
// CPU bus decoder with sprite-page DMA. Each req item is a CPU write, a CPU
// read or one master clock tick; each gives exactly one rsp item. Work RAM is
// RAM_BYTES bytes (a power of two) mirrored over 0x0000-0x1FFF. A write to
// 0x4014 starts a 256-byte page DMA that runs on ticks: a tick on phase 0
// fetches a byte (shown on dma_byte with dma_byte_index), a tick on phase 3
// steps the index; when no DMA runs those ticks raise cpu_clock_enable.
// After reset the block zeroes the work RAM, one byte per cycle, with
// req_ready low. After that one item is accepted per cycle while fewer than
// two are in flight or a result is taken; each goes through the decode
// register (with the registered RAM read), then a two-entry output buffer
// to rsp, which keeps req flowing while a result waits to be taken.
module console_bus_decode_with_sprite_dma #(
	parameter int unsigned RAM_BYTES = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cbd_pkg::cbd_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cbd_pkg::cbd_rsp_t rsp
);

	import cbd_pkg::*;

	localparam int unsigned AW = $clog2(RAM_BYTES);

	// ram clear sweep after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic          fire;
	logic          pop;
	cbd_ram_acc_t  ram_acc;
	logic          s1_valid;
	cbd_s1_t       s1;
	cbd_rsp_t      s1_rsp;
	logic [7:0]    ram_rdata;
	logic [1:0]    buf_count;
	logic [1:0]    occupancy;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(RAM_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// items in flight: decode stage plus output buffer, held to two so the
	// decode stage always drains next cycle and the ram read data is caught
	assign occupancy = buf_count + {1'b0, s1_valid};
	assign pop       = rsp_valid & rsp_ready;
	assign req_ready = ~clr_busy_q & ((occupancy < 2'd2) | pop);
	assign fire      = req_valid & req_ready;

	cbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.req      (req),
		.ram_acc  (ram_acc),
		.s1_valid (s1_valid),
		.s1       (s1)
	);

	// clear sweep owns the write port while no item is accepted
	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 8'd0;
		end else begin
			ram_we    = ram_acc.we;
			ram_waddr = ram_acc.waddr[AW-1:0];
			ram_wdata = ram_acc.wdata;
		end
	end

	cbd_ram #(
		.WIDTH (8),
		.DEPTH (RAM_BYTES)
	) u_work_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_acc.re),
		.raddr (ram_acc.raddr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// merge the ram byte into the decoded result
	always_comb begin
		s1_rsp = s1.rsp;
		if (s1.rd_from_ram) begin
			s1_rsp.rdata = ram_rdata;
		end
		if (s1.dma_from_ram) begin
			s1_rsp.dma_byte = ram_rdata;
		end
	end

	cbd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid),
		.push_data (s1_rsp),
		.pop       (pop),
		.count     (buf_count),
		.head      (rsp)
	);

	assign rsp_valid = (buf_count != 2'd0);

endmodule
